// ----- design/sha_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;
    localparam int QueueDepth = 4;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_item;

    localparam logic KindByte = 1'b0;
    localparam logic KindEnd  = 1'b1;

    localparam logic [255:0] InitHash = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        unique case (t)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage
`default_nettype wire

// ----- design/sha_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sha_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sha_pkg::t_item i_item,
    output logic               o_full,
    input  wire logic          i_pop,
    output sha_pkg::t_item     o_item,
    output logic               o_empty
);
    import sha_pkg::*;
    localparam int Aw = $clog2(QueueDepth);

    t_item             r_mem [QueueDepth];
    logic [Aw-1:0]     r_wr, r_rd;
    logic [Aw:0]       r_cnt;
    logic              w_do_push, w_do_pop;

    assign o_full    = (r_cnt == (Aw+1)'(QueueDepth));
    assign o_empty   = (r_cnt == '0);
    assign o_item    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) r_wr <= r_wr + 1'b1;
            if (w_do_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (Aw+1)'(w_do_push) - (Aw+1)'(w_do_pop);
        end
    end
endmodule
`default_nettype wire

// ----- design/sha_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sha_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sha_pkg::t_item i_item,
    input  wire logic           i_empty,
    output logic                o_pop,
    output logic [31:0]         o_digest_word,
    output logic                o_last_word,
    output logic                o_empty,
    input  wire logic           i_pop
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_ROUND, S_FEED, S_EMIT
    } t_state;

    t_state        r_state;
    // The block is held as sixteen big-endian words, filled one byte at a time.
    logic [31:0]   r_buf [16];
    logic [5:0]    r_fill;
    logic [63:0]   r_bits;
    logic [63:0]   r_total;
    logic          r_final;   // block under compression is the last of a message
    logic          r_second;  // a second padding block is still needed
    logic [5:0]    r_pos;
    logic [5:0]    r_t;
    logic [31:0]   r_w [16];
    logic [31:0]   r_v [8];
    logic [255:0]  r_h;
    logic [2:0]    r_oidx;
    logic [31:0]   w_wt, w_wnew, w_t1, w_t2, w_s0, w_s1;
    logic [7:0]    w_pad_byte;
    logic [5:0]    w_lp;

    // The schedule is a 16-word sliding window; word 0 is the current one.
    assign w_s0   = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign w_s1   = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_wnew = r_w[0] + w_s0 + r_w[9] + w_s1;
    assign w_wt   = r_w[0];
    assign w_t1   = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
                  + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_k(r_t) + w_wt;
    assign w_t2   = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
                  + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    assign w_lp = r_pos - 6'd56;
    always_comb begin
        if (r_pos >= 6'd56 && !r_second) begin
            w_pad_byte = r_total[8*(7 - w_lp[2:0]) +: 8];
        end else begin
            w_pad_byte = 8'h00;
        end
    end

    assign o_pop         = (r_state == S_IDLE) && !i_empty;
    assign o_empty       = (r_state != S_EMIT);
    assign o_digest_word = r_h[255 - 32*r_oidx -: 32];
    assign o_last_word   = (r_oidx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_bits   <= '0;
            r_h      <= InitHash;
            r_oidx   <= '0;
            r_final  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_item.kind == KindByte) begin
                            r_buf[r_fill[5:2]][{~r_fill[1:0], 3'd0} +: 8] <= i_item.data_byte;
                            r_fill        <= r_fill + 1'b1;
                            if (r_fill == 6'd63) begin
                                r_final <= 1'b0;
                                r_t     <= '0;
                                r_pos   <= '0;
                                r_state <= S_ROUND;
                                r_bits  <= r_bits + 64'd512;
                            end
                        end else begin
                            r_buf[r_fill[5:2]][{~r_fill[1:0], 3'd0} +: 8] <= 8'h80;
                            r_total  <= r_bits + {55'd0, r_fill, 3'd0};
                            r_second <= (r_fill >= 6'd56);
                            r_pos    <= r_fill + 1'b1;
                            r_final  <= 1'b1;
                            // With the marker at byte 63 the first block is already full.
                            r_state  <= (r_fill == 6'd63) ? S_ROUND : S_PAD;
                            r_t      <= '0;
                        end
                    end
                end
                S_PAD: begin
                    r_buf[r_pos[5:2]][{~r_pos[1:0], 3'd0} +: 8] <= w_pad_byte;
                    r_pos        <= r_pos + 1'b1;
                    if (r_pos == 6'd63) begin
                        r_state <= S_ROUND;
                        r_t     <= '0;
                    end
                end
                S_ROUND: begin
                    // r_t counts 0..63; loading of the window happens at round 0
                    // through r_pos, which walks the buffer one word per cycle first.
                    if (r_pos[5] == 1'b0 && r_pos[4] == 1'b0 && r_t == 6'd0) begin
                        for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                        r_w[15] <= r_buf[r_pos[3:0]];
                        if (r_pos[3:0] == 4'd15) begin
                            r_pos <= 6'd32;
                            for (int i = 0; i < 8; i++) r_v[i] <= r_h[255-32*i -: 32];
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end else begin
                        r_v[0] <= w_t1 + w_t2;
                        r_v[1] <= r_v[0];
                        r_v[2] <= r_v[1];
                        r_v[3] <= r_v[2];
                        r_v[4] <= r_v[3] + w_t1;
                        r_v[5] <= r_v[4];
                        r_v[6] <= r_v[5];
                        r_v[7] <= r_v[6];
                        for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                        r_w[15] <= w_wnew;
                        r_t     <= r_t + 1'b1;
                        if (r_t == 6'd63) r_state <= S_FEED;
                    end
                end
                S_FEED: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[255-32*i -: 32] <= r_h[255-32*i -: 32] + r_v[i];
                    end
                    r_fill <= '0;
                    if (!r_final) begin
                        r_state <= S_IDLE;
                    end else if (r_second) begin
                        r_second <= 1'b0;
                        r_pos    <= '0;
                        r_state  <= S_PAD;
                    end else begin
                        r_oidx  <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_pop) begin
                        r_oidx <= r_oidx + 1'b1;
                        if (r_oidx == 3'd7) begin
                            r_h     <= InitHash;
                            r_bits  <= '0;
                            r_final <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/sha256_stream_hasher_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// SHA-256 over a byte stream.
// Input channel: push/full. Each item is a message byte (kind 0) or an
// end-of-message mark (kind 1). A four-entry queue decouples the sender
// from the hashing core.
// Result channel: empty/pop. An end mark yields eight digest words, the most
// significant first, the last one flagged by o_last_word.
// The core takes bytes while idle; the 64th byte of a block starts loading
// of the schedule, the rounds and the feed-forward step.
// An end mark adds padding up to the block end, one or two compressions,
// then the words wait for pop, one per cycle at best.
// Throughput is set by the single round unit; the core takes no byte
// while a block is compressed.
// While the receiver stalls the digest is held and the core takes no item;
// the queue still accepts up to four items.
// Reset (synchronous, active low) restores the initial hash value and
// discards queued items and any partial block.
module sha256_stream_hasher_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_data_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_digest_word,
    output logic             o_last_word
);
    import sha_pkg::*;

    t_item w_in, w_q;
    logic  w_qempty, w_qpop;

    assign w_in.kind      = i_kind;
    assign w_in.data_byte = i_data_byte;

    sha_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_item(w_in),
        .o_full(full), .i_pop(w_qpop), .o_item(w_q), .o_empty(w_qempty)
    );

    sha_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(w_q), .i_empty(w_qempty),
        .o_pop(w_qpop), .o_digest_word(o_digest_word), .o_last_word(o_last_word),
        .o_empty(empty), .i_pop(pop)
    );

`ifndef SYNTHESIS
    a_no_take_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !w_qpop) else $error("core took an item while emitting");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_last_word) |=> empty) else $error("digest did not end");
`endif
endmodule
`default_nettype wire
